### hw/rtl/signed_binary_to_decimal_ascii_core_assert.svh
// Assertion macros for the signed binary to decimal ASCII core.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SBDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SBDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SBDA_ASSERT_NOW(label, ante, cons)

`define SBDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/sbda_pkg.sv
// Shared constants and types for the signed binary to decimal ASCII core.
`timescale 1ns / 1ps

package sbda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic digit_shift;
  } sbda_ctrl_t;

  typedef struct packed {
    logic busy;
  } sbda_stat_t;

endpackage

### hw/rtl/sbda_dabble.sv
// Bit-serial binary to BCD converter with a digit-wide shift-out path.
`timescale 1ns / 1ps

module sbda_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  sbda_pkg::sbda_ctrl_t          ctrl,
  input  logic [sbda_pkg::VALUE_W-1:0]  mag,
  output sbda_pkg::sbda_stat_t          stat,
  output logic [sbda_pkg::DIGIT_W-1:0]  digit
);
  import sbda_pkg::*;

  logic [VALUE_W-1:0]   mag_sr;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 busy;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.load) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_sr <= mag;
      bcd    <= '0;
    end else if (busy) begin
      mag_sr <= {mag_sr[VALUE_W-2:0], 1'b0};
      bcd    <= {bcd_adj[BCD_W-2:0], mag_sr[VALUE_W-1]};
    end else if (ctrl.digit_shift) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign stat.busy = busy;
  assign digit     = bcd[BCD_W-1 -: DIGIT_W];

endmodule

### hw/rtl/signed_binary_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Input channel: in_valid / in_ready with value, a signed 32-bit integer.
// Output channel: out_valid / out_ready with character (ASCII) and last_char,
// which marks the final character of each value's text.
// Each value gives a minus sign when negative, then its decimal digits,
// most significant first, with leading zeros dropped; zero gives one '0'.
// One value at a time. After a transfer in, the shift-and-add-three converter
// takes one input bit per cycle. A negative value then passes the sign state,
// which waits for a free output slot. The digit scan steps through all ten BCD
// digits, one per cycle, whether the digit is sent or dropped; a digit to be
// sent waits for a free output slot.
// in_ready is high only while no conversion or scan runs; the last character
// may still wait in the output register while the next value is taken.
// A low out_ready holds the output register and stalls the digit scan.
// Reset clears the control state and drops any pending character.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_assert.svh"

module signed_binary_to_decimal_ascii_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sbda_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sbda_pkg::CHAR_W-1:0]         character,
  output logic                                last_char
);
  import sbda_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic                 neg;
  logic                 started;
  logic [DIG_CNT_W-1:0] dig_cnt;
  logic [VALUE_W-1:0]   mag;
  logic [DIGIT_W-1:0]   digit;
  logic                 slot_free;
  logic                 is_last;
  logic                 show;
  logic                 in_xfer;
  logic                 char_load;
  sbda_ctrl_t           ctrl;
  sbda_stat_t           stat;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign mag       = value[VALUE_W-1] ? VALUE_W'(0 - value) : VALUE_W'(value);
  assign slot_free = !out_valid || out_ready;
  assign is_last   = (dig_cnt == DIG_CNT_W'(MAX_DIGITS - 1));
  assign show      = started || (digit != '0) || is_last;

  assign ctrl.load        = in_xfer;
  assign ctrl.digit_shift = (state == S_EMIT) && (!show || slot_free);

  assign char_load = ((state == S_SIGN) && slot_free) ||
                     ((state == S_EMIT) && ctrl.digit_shift && show);

  sbda_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .mag   (mag),
    .stat  (stat),
    .digit (digit)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_CONV;
      end
      S_CONV: begin
        if (!stat.busy) state_next = neg ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (slot_free) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (ctrl.digit_shift && is_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
      dig_cnt   <= '0;
    end else begin
      state <= state_next;
      if (char_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          started <= 1'b0;
          dig_cnt <= '0;
        end
        S_EMIT: begin
          if (ctrl.digit_shift) begin
            dig_cnt <= dig_cnt + DIG_CNT_W'(1);
            if (show) started <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg <= value[VALUE_W-1];
    end
    if ((state == S_SIGN) && slot_free) begin
      character <= ASCII_MINUS;
      last_char <= 1'b0;
    end else if ((state == S_EMIT) && ctrl.digit_shift && show) begin
      character <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
      last_char <= is_last;
    end
  end

  `SBDA_ASSERT_NEXT(a_load_starts_conv, in_valid && in_ready, (state == S_CONV) && stat.busy)
  `SBDA_ASSERT_NOW(a_sign_only_negative, state == S_SIGN, neg && !stat.busy)
  `SBDA_ASSERT_NOW(a_char_legal, out_valid, (character == ASCII_MINUS) || ((character >= ASCII_ZERO) && (character <= ASCII_NINE)))
  `SBDA_ASSERT_NOW(a_minus_not_last, out_valid && (character == ASCII_MINUS), !last_char)

endmodule

### verif/tb_signed_binary_to_decimal_ascii_core.sv
// Testbench for the signed binary to decimal ASCII core: directed and random values.
`timescale 1ns / 1ps

class decimal_text_scoreboard;
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches;
  int         chars_seen;

  function new();
    mismatches = 0;
    chars_seen = 0;
  endfunction

  function void note_value(logic [31:0] v);
    logic [32:0] mag;
    logic [3:0]  digs [10];
    int          n;
    text_char_t  t;
    n   = 0;
    mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    if (mag == 0) begin
      t.ch   = sbda_pkg::ASCII_ZERO;
      t.last = 1'b1;
      expected_text.push_back(t);
      return;
    end
    while (mag != 0 && n < 10) begin
      digs[n] = 4'(mag % 10);
      mag     = mag / 10;
      n++;
    end
    if (v[31]) begin
      t.ch   = sbda_pkg::ASCII_MINUS;
      t.last = 1'b0;
      expected_text.push_back(t);
    end
    for (int k = n - 1; k >= 0; k--) begin
      t.ch   = sbda_pkg::ASCII_ZERO + 8'(digs[k]);
      t.last = (k == 0);
      expected_text.push_back(t);
    end
  endfunction

  function void check_char(logic [7:0] ch, logic last);
    text_char_t t;
    chars_seen++;
    if (expected_text.size() == 0) begin
      $display("%0t: unexpected character: expected none actual char=%h last=%b",
               $time, ch, last);
      mismatches++;
      return;
    end
    t = expected_text.pop_front();
    if (ch !== t.ch) begin
      $display("%0t: character mismatch: expected %h actual %h", $time, t.ch, ch);
      mismatches++;
    end
    if (last !== t.last) begin
      $display("%0t: last_char mismatch: expected %b actual %b", $time, t.last, last);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return expected_text.size();
  endfunction
endclass

module tb_signed_binary_to_decimal_ascii_core;
  import sbda_pkg::*;

  localparam int NUM_RANDOM  = 212;
  localparam int NUM_CORNERS = 18;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_OFF    = 400;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [VALUE_W-1:0]  value;
  logic                       out_valid;
  logic                       out_ready;
  logic [CHAR_W-1:0]          character;
  logic                       last_char;

  decimal_text_scoreboard sb = new();
  int idle_cycles;
  bit held_off;

  signed_binary_to_decimal_ascii_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last_char (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] corner_value(int idx);
    case (idx)
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return -32'sd1;
      3:       return 32'd9;
      4:       return 32'd10;
      5:       return -32'sd10;
      6:       return 32'h7FFF_FFFF;
      7:       return 32'h8000_0000;
      8:       return 32'h8000_0001;
      9:       return 32'd1000000000;
      10:      return -32'sd1000000000;
      11:      return 32'd999999999;
      12:      return 32'd100;
      13:      return -32'sd5;
      14:      return 32'h5555_5555;
      15:      return 32'hAAAA_AAAA;
      16:      return 32'd1234567890;
      default: return -32'sd1234567890;
    endcase
  endfunction

  function automatic logic [31:0] random_value();
    int unsigned kind;
    int          k;
    longint      mag;
    logic [31:0] v;
    kind = $urandom_range(0, 3);
    mag  = 1;
    case (kind)
      0: v = $urandom();
      1: begin
        k = $urandom_range(1, 9);
        repeat (k) mag = mag * 10;
        v = 32'($urandom_range(0, 32'(mag)));
      end
      2: begin
        k = $urandom_range(0, 9);
        repeat (k) mag = mag * 10;
        v = 32'(mag + $urandom_range(0, 2) - 1);
      end
      default: begin
        if ($urandom_range(0, 1))
          v = 32'h8000_0000 + $urandom_range(0, 15);
        else
          v = 32'h7FFF_FFFF - $urandom_range(0, 15);
      end
    endcase
    if ((kind == 1 || kind == 2) && $urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  task automatic send_value(logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_value(v);
  endtask

  task automatic drain_text();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_CORNERS; i++) send_value(corner_value(i));
    drain_text();
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_value(random_value());
      if (i == NUM_RANDOM / 2) drain_text();
    end
    drain_text();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int off;
    out_ready <= 1'b0;
    held_off  = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 80)) @(posedge clk);
      if (!held_off && sb.chars_seen >= 60) begin
        held_off = 1'b1;
        off      = HOLD_OFF;
      end else begin
        off = pick_gap();
      end
      if (off > 0) begin
        out_ready <= 1'b0;
        repeat (off) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_char(character, last_char);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
